@@ src/e2q_pkg.sv @@
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int PI_Q30_W = 33;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] heading_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] bank_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } e2q_out_t;

  // Arctangent table in Q30; entry 0 is pi/4, entries past 31 are zero.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] t;
    case (i)
      0: t = 34'sd843314857;
      1: t = 34'sd497837829;
      2: t = 34'sd263043837;
      3: t = 34'sd133525159;
      4: t = 34'sd67021687;
      5: t = 34'sd33543516;
      6: t = 34'sd16775851;
      7: t = 34'sd8388437;
      8: t = 34'sd4194283;
      9: t = 34'sd2097149;
      10: t = 34'sd1048576;
      11: t = 34'sd524288;
      12: t = 34'sd262144;
      13: t = 34'sd131072;
      14: t = 34'sd65536;
      15: t = 34'sd32768;
      16: t = 34'sd16384;
      17: t = 34'sd8192;
      18: t = 34'sd4096;
      19: t = 34'sd2048;
      20: t = 34'sd1024;
      21: t = 34'sd512;
      22: t = 34'sd256;
      23: t = 34'sd128;
      24: t = 34'sd64;
      25: t = 34'sd32;
      26: t = 34'sd16;
      27: t = 34'sd8;
      28: t = 34'sd4;
      29: t = 34'sd2;
      30: t = 34'sd1;
      31: t = 34'sd1;
      default: t = 34'sd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ src/e2q_cordic_cell.sv @@
`default_nettype none
module e2q_cordic_cell
  import e2q_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] x_in [3],
  input  wire logic signed [33:0] y_in [3],
  input  wire logic signed [33:0] z_in [3],
  output logic signed [33:0]      x_out [3],
  output logic signed [33:0]      y_out [3],
  output logic signed [33:0]      z_out [3]
);

  localparam logic signed [33:0] T = atan_q30(STAGE);

  // Rotate each of the three angle lanes by one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (!z_in[k][33]) begin
          x_out[k] <= x_in[k] - (y_in[k] >>> STAGE);
          y_out[k] <= y_in[k] + (x_in[k] >>> STAGE);
          z_out[k] <= z_in[k] - T;
        end else begin
          x_out[k] <= x_in[k] + (y_in[k] >>> STAGE);
          y_out[k] <= y_in[k] - (x_in[k] >>> STAGE);
          z_out[k] <= z_in[k] + T;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/euler_to_quaternion.sv @@
`default_nettype none
// Converts heading, pitch and bank binary angles (half the code range is 180
// degrees) to a Q1.15 rotation quaternion, one transaction per cycle. Each
// half angle runs down a row of CORDIC_STAGES rotation cells; then a
// round/clamp stage, two multiply stages and a round/saturate stage form w,
// x, y, z. The whole pipe advances when the output is not stalled.
// frame_mode = 1 negates x, y and z (object-to-inertial form).
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire e2q_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output e2q_out_t      out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  localparam int LAT = CORDIC_STAGES + 5;
  localparam int PW  = ANGLE_BITS + PI_Q30_W + 1;

  logic frame_mode;
  logic en;
  logic [LAT-1:0] vld;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[LAT-1];

  // Hold the frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      frame_mode <= cfg_data;
    end
  end

  // Advance valid bits along the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage 0: angle to Q30 half-angle radians
  logic signed [33:0] xs [CORDIC_STAGES+1][3];
  logic signed [33:0] ys [CORDIC_STAGES+1][3];
  logic signed [33:0] zs [CORDIC_STAGES+1][3];
  logic signed [ANGLE_BITS-1:0] ang [3];
  logic signed [PW-1:0] prod [3];

  assign ang[0] = in_data.heading_angle[ANGLE_BITS-1:0];
  assign ang[1] = in_data.pitch_angle[ANGLE_BITS-1:0];
  assign ang[2] = in_data.bank_angle[ANGLE_BITS-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PW'(ang[k]) * PW'($signed({1'b0, PI_Q30}));
      prod[k] = prod[k] + ($signed({{(ANGLE_BITS+PI_Q30_W){1'b0}}, 1'b1}) <<< (ANGLE_BITS-1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        xs[0][k] <= GAIN_Q30;
        ys[0][k] <= '0;
        zs[0][k] <= 34'(prod[k] >>> ANGLE_BITS);
      end
    end
  end

  // Row of rotation cells
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    e2q_cordic_cell #(.STAGE(g)) u_cell (
      .clk(clk), .en(en),
      .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]),
      .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1])
    );
  end

  // Round to Q15 and clamp to +-1.0
  function automatic logic signed [16:0] to_unit(input logic signed [33:0] v);
    logic signed [34:0] r;
    logic signed [19:0] q;
    r = 35'(v) + 35'sd16384;
    q = 20'(r >>> 15);
    if (q > 20'sd32768) return 17'sd32768;
    if (q < -20'sd32768) return -17'sd32768;
    return 17'(q);
  endfunction

  logic signed [16:0] cs [3], sn [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cs[k] <= to_unit(xs[CORDIC_STAGES][k]);
        sn[k] <= to_unit(ys[CORDIC_STAGES][k]);
      end
    end
  end

  // Pair products of heading and pitch
  logic signed [33:0] cc, ss, cs_hp, sc_hp;
  logic signed [16:0] cb1, sb1;
  always_ff @(posedge clk) begin
    if (en) begin
      cc    <= 34'(cs[0]) * 34'(cs[1]);
      ss    <= 34'(sn[0]) * 34'(sn[1]);
      cs_hp <= 34'(cs[0]) * 34'(sn[1]);
      sc_hp <= 34'(sn[0]) * 34'(cs[1]);
      cb1   <= cs[2];
      sb1   <= sn[2];
    end
  end

  // Triple products with bank
  logic signed [50:0] p [8];
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= 51'(cc) * 51'(cb1);    p[1] <= 51'(ss) * 51'(sb1);
      p[2] <= 51'(cs_hp) * 51'(cb1); p[3] <= 51'(sc_hp) * 51'(sb1);
      p[4] <= 51'(sc_hp) * 51'(cb1); p[5] <= 51'(cs_hp) * 51'(sb1);
      p[6] <= 51'(cc) * 51'(sb1);    p[7] <= 51'(ss) * 51'(cb1);
    end
  end

  function automatic logic signed [15:0] to_q15(input logic signed [51:0] v);
    logic signed [51:0] r;
    r = (v + 52'sd536870912) >>> 30;
    if (r > 52'sd32767) return 16'sh7fff;
    if (r < -52'sd32768) return 16'sh8000;
    return 16'(r);
  endfunction

  // Sum, apply frame sign, round and saturate
  logic signed [51:0] sw, sx, sy, sz;
  always_comb begin
    sw = 52'(p[0]) + 52'(p[1]);
    sx = 52'(p[2]) + 52'(p[3]);
    sy = 52'(p[4]) - 52'(p[5]);
    sz = 52'(p[6]) - 52'(p[7]);
    if (frame_mode) begin
      sx = -sx; sy = -sy; sz = -sz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.quat_w <= to_q15(sw);
      out_data.quat_x <= to_q15(sx);
      out_data.quat_y <= to_q15(sy);
      out_data.quat_z <= to_q15(sz);
    end
  end

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Input is taken exactly when the pipe advances
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // An accepted item enters the pipe
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item lost");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
module tb;
  import e2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16 + 5;
  localparam longint PI_Q = 64'd3373259426;
  localparam longint GAIN_Q = 64'd652032874;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  e2q_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  e2q_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  e2q_out_t quat_queue[$];
  logic frame_sel = 1'b0;
  int errors = 0;
  bit stall_on = 1'b1;
  int out_wait = 0;
  longint atan_tab[16];

  euler_to_quaternion i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 32768) return 32768;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Arctangent series in Q60, each term truncated, then rounded to Q30; entry 0 is pi/4
  function automatic longint series_atan(int i);
    longint acc;
    int e;
    acc = 0;
    if (i == 0) return rshift(PI_Q, 2);
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      if (k % 2) acc -= (longint'(1) << (60 - e)) / (2 * k + 1);
      else acc += (longint'(1) << (60 - e)) / (2 * k + 1);
    end
    return rshift(acc, 30);
  endfunction

  // Rotate the gain vector through half the binary angle
  task automatic half_angle_trig(logic signed [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    z = rshift(longint'(ang) * PI_Q, 16);
    x = GAIN_Q;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = clamp_one(rshift(x, 15));
    s = clamp_one(rshift(y, 15));
  endtask

  function automatic logic signed [15:0] sat_q15(longint v, bit neg);
    longint r;
    r = rshift(neg ? -v : v, 30);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_quat(e2q_in_t a, output e2q_out_t q);
    longint ch, sh, cp, sp, cb, sb;
    half_angle_trig(a.heading_angle, ch, sh);
    half_angle_trig(a.pitch_angle, cp, sp);
    half_angle_trig(a.bank_angle, cb, sb);
    q.quat_w = sat_q15(ch * cp * cb + sh * sp * sb, 1'b0);
    q.quat_x = sat_q15(ch * sp * cb + sh * cp * sb, frame_sel);
    q.quat_y = sat_q15(sh * cp * cb - ch * sp * sb, frame_sel);
    q.quat_z = sat_q15(ch * cp * sb - sh * sp * cb, frame_sel);
  endtask

  // Send one angle triple, after a random gap; valid drops only for a gap
  task automatic send_angles(logic signed [15:0] h, logic signed [15:0] p,
                             logic signed [15:0] b);
    e2q_in_t a;
    e2q_out_t q;
    int gap;
    gap = $urandom_range(0, 19);
    if (!stall_on) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    a.heading_angle = h;
    a.pitch_angle = p;
    a.bank_angle = b;
    in_valid <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_quat(a, q);
    quat_queue.push_back(q);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write the frame register while the pipe is empty
  task automatic write_frame(logic m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frame_sel = m;
  endtask

  // Draw a stall length for each result, with a quiet stretch now and then
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      out_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_wait = $urandom_range(0, 19);
      else if (out_wait > 0) out_wait--;
      out_stall <= (out_wait > 0);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    e2q_out_t q;
    if (!rst && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $display("%t unexpected result %h", $realtime, out_data);
        errors++;
      end else begin
        q = quat_queue.pop_front();
        if (q.quat_w !== out_data.quat_w)
          $display("%t quat_w exp %0d got %0d", $realtime, q.quat_w, out_data.quat_w);
        if (q.quat_x !== out_data.quat_x)
          $display("%t quat_x exp %0d got %0d", $realtime, q.quat_x, out_data.quat_x);
        if (q.quat_y !== out_data.quat_y)
          $display("%t quat_y exp %0d got %0d", $realtime, q.quat_y, out_data.quat_y);
        if (q.quat_z !== out_data.quat_z)
          $display("%t quat_z exp %0d got %0d", $realtime, q.quat_z, out_data.quat_z);
        if (q !== out_data) errors++;
      end
    end
  end

  task automatic test_extremes();
    logic signed [15:0] v[6];
    v = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh4000, 16'shc000, 16'sh0001};
    send_angles(16'sh0000, 16'sh0000, 16'sh0000);
    for (int i = 0; i < 6; i++) begin
      send_angles(v[i], 16'sh0000, 16'sh0000);
      send_angles(16'sh0000, v[i], 16'sh0000);
      send_angles(16'sh0000, 16'sh0000, v[i]);
    end
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 150) stall_on = 1'b0;
      if (i % 300 == 200) stall_on = 1'b1;
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_pause();
    drain_results();
    test_random(20);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) atan_tab[i] = series_atan(i);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    write_frame(1'b1);
    test_extremes();
    test_random(500);
    test_pause();
    write_frame(1'b0);
    test_random(500);
    write_frame(1'b1);
    test_random(460);
    drain_results();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
